### design/page_victim_selector_assert.svh
// Assertion macros for the page victim selector.
`ifndef PAGE_VICTIM_SELECTOR_ASSERT_SVH
`define PAGE_VICTIM_SELECTOR_ASSERT_SVH

// Asserts that a condition implies another in the same cycle.
`define PVS_ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("implication failed");

// Asserts that a condition implies another in the next cycle.
`define PVS_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("next-cycle implication failed");

`endif

### design/pvs_pkg.sv
package pvs_pkg;

    localparam int ENTRIES_DEFAULT = 32;
    localparam int SWAP_SLOTS_DEFAULT = 16;

    localparam int CMD_W = 2;
    localparam int IDX_W = 5;
    localparam int PID_W = 16;
    localparam int SEQ_W = 16;
    localparam int STATUS_W = 2;
    localparam int SLOT_W = 4;

    localparam logic [CMD_W-1:0] CMD_PLACE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REFERENCE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_EVICT = 2'd2;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

    localparam logic [STATUS_W-1:0] ST_DONE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SLOT = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_VICTIM = 2'd2;

    localparam logic POLICY_LIFO = 1'b0;
    localparam logic POLICY_FIFO = 1'b1;

endpackage

### design/page_victim_selector.sv
// Page victim selector with LIFO and second-chance FIFO policies.
// Requests enter on in_valid/in_stall (cmd, entry_index, page_id); each request
// gives exactly one result on out_valid/out_stall (status, victim_entry,
// victim_page_id, swap_slot). cfg_valid/cfg_ready writes policy_mode.
// Entry data lives in one memory with a registered read port; the per-entry
// flags live in flip-flops. An evict first scans the swap slot table, one
// slot per cycle, then scans the entry table, one entry per cycle, with
// each entry read from the memory in the cycle before it is compared.
// In second-chance mode every re-queue costs another entry scan, so an
// evict with R re-queues scans the entry table R + 1 times, R <= ENTRIES.
// One request is in progress at a time; in_stall is high until the result
// has been taken. A stalled result holds its value on the output ports.
// Reset clears all flags, the slot table, the sequence counter and sets the
// policy to second-chance FIFO; it takes effect at once with no sweep.
// Entry page ids and sequence numbers are only read for active entries, and
// release clears the flags, so no clearing pass of the memory is needed.
module page_victim_selector
    import pvs_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEFAULT,
    parameter int SWAP_SLOTS = SWAP_SLOTS_DEFAULT
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [IDX_W-1:0]    entry_index,
    input  logic [PID_W-1:0]    page_id,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [IDX_W-1:0]    victim_entry,
    output logic [PID_W-1:0]    victim_page_id,
    output logic [SLOT_W-1:0]   swap_slot,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                policy_mode
);
`include "page_victim_selector_assert.svh"

    localparam int EW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int SW = (SWAP_SLOTS > 1) ? $clog2(SWAP_SLOTS) : 1;
    localparam int ECW = $clog2(ENTRIES + 1);
    localparam int SCW = $clog2(SWAP_SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SLOT, S_SCAN, S_DECIDE, S_FINISH, S_OUT
    } state_t;

    typedef struct packed {
        logic [SEQ_W-1:0] seq;
        logic [PID_W-1:0] pid;
    } entry_t;

    entry_t                 entry_mem [ENTRIES];
    entry_t                 rd_reg;
    logic [EW-1:0]          rd_addr;
    logic                   wr_en;
    logic [EW-1:0]          wr_addr;
    entry_t                 wr_data;

    logic [PID_W-1:0]       slot_mem [SWAP_SLOTS];
    logic [PID_W-1:0]       slot_rd_reg;
    logic [SW-1:0]          slot_rd_addr;

    state_t                 state_reg;
    logic [ENTRIES-1:0]     active_reg;
    logic [ENTRIES-1:0]     present_reg;
    logic [ENTRIES-1:0]     refd_reg;
    logic [SEQ_W-1:0]       seq_cnt_reg;
    logic                   policy_reg;
    logic [CMD_W-1:0]       cmd_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [PID_W-1:0]       pid_reg;
    logic [SCW-1:0]         scnt_reg;
    logic [SW-1:0]          slot_reg;
    logic [ECW-1:0]         ecnt_reg;
    logic                   rd_ok_reg;
    logic [EW-1:0]          rd_idx_reg;
    logic                   best_ok_reg;
    logic [EW-1:0]          best_reg;
    logic [SEQ_W-1:0]       best_age_reg;
    logic [PID_W-1:0]       best_pid_reg;
    logic [ECW-1:0]         requeue_reg;
    logic                   out_valid_reg;
    logic [STATUS_W-1:0]    status_reg;
    logic [IDX_W-1:0]       victim_entry_reg;
    logic [PID_W-1:0]       victim_page_id_reg;
    logic [SLOT_W-1:0]      swap_slot_reg;

    logic                   in_fire;
    logic                   idx_ok;
    logic [EW-1:0]          idx_e;
    logic [SEQ_W-1:0]       rd_age;
    logic                   rd_cand;
    logic                   better;
    logic                   slot_wr_en;

    assign in_fire = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !in_valid;
    assign idx_ok = (ENTRIES'(32'd0) == '0) && (32'(idx_reg) < ENTRIES);
    assign idx_e = EW'(idx_reg);
    assign rd_age = seq_cnt_reg - rd_reg.seq;
    assign rd_cand = rd_ok_reg && active_reg[rd_idx_reg] && present_reg[rd_idx_reg];
    assign slot_wr_en = (state_reg == S_FINISH);

    always_comb
    begin
        if (!best_ok_reg)
        begin
            better = 1'b1;
        end
        else if (policy_reg == POLICY_FIFO)
        begin
            better = rd_age > best_age_reg;
        end
        else
        begin
            better = rd_age < best_age_reg;
        end
    end

    always_comb
    begin
        rd_addr = EW'(ecnt_reg);
        wr_en = 1'b0;
        wr_addr = idx_e;
        wr_data.seq = seq_cnt_reg;
        wr_data.pid = pid_reg;
        if (state_reg == S_DECIDE && best_ok_reg && refd_reg[best_reg]
            && policy_reg == POLICY_FIFO && requeue_reg < ECW'(ENTRIES))
        begin
            wr_en = 1'b1;
            wr_addr = best_reg;
            wr_data.pid = best_pid_reg;
        end
        else if (state_reg == S_FINISH)
        begin
            wr_en = 1'b1;
            wr_addr = best_reg;
            wr_data.seq = '0;
            wr_data.pid = best_pid_reg;
        end
        else if (state_reg == S_SLOT && scnt_reg == '0 && idx_ok
                 && (cmd_reg == CMD_PLACE || cmd_reg == CMD_RELEASE))
        begin
            wr_en = 1'b1;
            if (cmd_reg == CMD_RELEASE)
            begin
                wr_data = '0;
            end
        end
    end

    assign slot_rd_addr = SW'(scnt_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_mem[wr_addr] <= wr_data;
        end
        rd_reg <= entry_mem[rd_addr];
        slot_rd_reg <= slot_mem[slot_rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SWAP_SLOTS; i++)
            begin
                slot_mem[i] <= '0;
            end
        end
        else if (slot_wr_en)
        begin
            slot_mem[slot_reg] <= best_pid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            active_reg <= '0;
            present_reg <= '0;
            refd_reg <= '0;
            seq_cnt_reg <= '0;
            policy_reg <= POLICY_FIFO;
            cmd_reg <= CMD_PLACE;
            idx_reg <= '0;
            pid_reg <= '0;
            scnt_reg <= '0;
            slot_reg <= '0;
            ecnt_reg <= '0;
            rd_ok_reg <= 1'b0;
            rd_idx_reg <= '0;
            best_ok_reg <= 1'b0;
            best_reg <= '0;
            best_age_reg <= '0;
            best_pid_reg <= '0;
            requeue_reg <= '0;
            out_valid_reg <= 1'b0;
            status_reg <= ST_DONE;
            victim_entry_reg <= '0;
            victim_page_id_reg <= '0;
            swap_slot_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                policy_reg <= policy_mode;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        cmd_reg <= cmd;
                        idx_reg <= entry_index;
                        pid_reg <= page_id;
                        scnt_reg <= '0;
                        state_reg <= S_SLOT;
                    end
                end
                S_SLOT:
                begin
                    status_reg <= ST_DONE;
                    victim_entry_reg <= '0;
                    victim_page_id_reg <= '0;
                    swap_slot_reg <= '0;
                    if (cmd_reg != CMD_EVICT)
                    begin
                        if (idx_ok)
                        begin
                            unique case (cmd_reg)
                                CMD_PLACE:
                                begin
                                    active_reg[idx_e] <= 1'b1;
                                    present_reg[idx_e] <= 1'b1;
                                    refd_reg[idx_e] <= 1'b0;
                                    seq_cnt_reg <= seq_cnt_reg + 1'b1;
                                end
                                CMD_REFERENCE:
                                begin
                                    if (active_reg[idx_e])
                                    begin
                                        refd_reg[idx_e] <= 1'b1;
                                    end
                                end
                                default:
                                begin
                                    active_reg[idx_e] <= 1'b0;
                                    present_reg[idx_e] <= 1'b0;
                                    refd_reg[idx_e] <= 1'b0;
                                end
                            endcase
                        end
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (scnt_reg != '0 && slot_rd_reg == '0)
                    begin
                        slot_reg <= SW'(scnt_reg - 1'b1);
                        ecnt_reg <= '0;
                        rd_ok_reg <= 1'b0;
                        best_ok_reg <= 1'b0;
                        requeue_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                    else if (scnt_reg == SCW'(SWAP_SLOTS))
                    begin
                        status_reg <= ST_NO_SLOT;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else
                    begin
                        scnt_reg <= scnt_reg + 1'b1;
                    end
                end
                S_SCAN:
                begin
                    if (rd_cand && better)
                    begin
                        best_ok_reg <= 1'b1;
                        best_reg <= rd_idx_reg;
                        best_age_reg <= rd_age;
                        best_pid_reg <= rd_reg.pid;
                    end
                    if (ecnt_reg == ECW'(ENTRIES))
                    begin
                        rd_ok_reg <= 1'b0;
                        state_reg <= S_DECIDE;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b1;
                        rd_idx_reg <= EW'(ecnt_reg);
                        ecnt_reg <= ecnt_reg + 1'b1;
                    end
                end
                S_DECIDE:
                begin
                    ecnt_reg <= '0;
                    if (!best_ok_reg)
                    begin
                        status_reg <= ST_NO_VICTIM;
                        out_valid_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (policy_reg == POLICY_FIFO && refd_reg[best_reg])
                    begin
                        if (requeue_reg >= ECW'(ENTRIES))
                        begin
                            status_reg <= ST_NO_VICTIM;
                            out_valid_reg <= 1'b1;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            refd_reg[best_reg] <= 1'b0;
                            seq_cnt_reg <= seq_cnt_reg + 1'b1;
                            requeue_reg <= requeue_reg + 1'b1;
                            best_ok_reg <= 1'b0;
                            state_reg <= S_SCAN;
                        end
                    end
                    else
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    present_reg[best_reg] <= 1'b0;
                    victim_entry_reg <= IDX_W'(best_reg);
                    victim_page_id_reg <= best_pid_reg;
                    swap_slot_reg <= SLOT_W'(slot_reg);
                    out_valid_reg <= 1'b1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!out_stall)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign status = status_reg;
    assign victim_entry = victim_entry_reg;
    assign victim_page_id = victim_page_id_reg;
    assign swap_slot = swap_slot_reg;

    `PVS_ASSERT_IMPLY(a_out_in_out_state, clk, rst_n, out_valid, state_reg == S_OUT)
    `PVS_ASSERT_IMPLY(a_victim_only_done, clk, rst_n, out_valid && status != ST_DONE,
        victim_page_id == '0 && victim_entry == '0 && swap_slot == '0)
    `PVS_ASSERT_NEXT(a_requeue_bounded, clk, rst_n, state_reg == S_DECIDE,
        requeue_reg <= ECW'(ENTRIES))

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import pvs_pkg::*;

    localparam int NUM_ENTRIES = 32;
    localparam int NUM_SLOTS = 16;
    localparam int PHASE_ITEMS = 350;

    typedef struct packed {
        logic [STATUS_W-1:0] st;
        logic [IDX_W-1:0]    ventry;
        logic [PID_W-1:0]    vpid;
        logic [SLOT_W-1:0]   slot;
    } evict_result_t;

    typedef struct {
        logic [CMD_W-1:0] c;
        logic [IDX_W-1:0] idx;
        logic [PID_W-1:0] pid;
        bit               typed;
        evict_result_t    res;
    } request_row_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [CMD_W-1:0]    cmd;
    logic [IDX_W-1:0]    entry_index;
    logic [PID_W-1:0]    page_id;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [IDX_W-1:0]    victim_entry;
    logic [PID_W-1:0]    victim_page_id;
    logic [SLOT_W-1:0]   swap_slot;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                policy_mode;

    logic                pm_policy;
    logic                pm_active [NUM_ENTRIES];
    logic                pm_present [NUM_ENTRIES];
    logic                pm_refd [NUM_ENTRIES];
    logic [SEQ_W-1:0]    pm_seq [NUM_ENTRIES];
    logic [PID_W-1:0]    pm_pid [NUM_ENTRIES];
    logic [PID_W-1:0]    pm_owner [NUM_SLOTS];
    logic [SEQ_W-1:0]    pm_seq_ctr;

    evict_result_t       pending_results [$];
    request_row_t        directed_rows [$];
    int                  errors;
    bit                  idle_on;
    int                  stall_left;

    page_victim_selector DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .cmd            (cmd),
        .entry_index    (entry_index),
        .page_id        (page_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .victim_entry   (victim_entry),
        .victim_page_id (victim_page_id),
        .swap_slot      (swap_slot),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .policy_mode    (policy_mode)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic int pick_page(bit oldest);
        int best;
        logic [SEQ_W-1:0] best_age;
        logic [SEQ_W-1:0] a;
        best = -1;
        best_age = '0;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            if (pm_active[e] && pm_present[e])
            begin
                a = pm_seq_ctr - pm_seq[e];
                if (best < 0 || (oldest ? (a > best_age) : (a < best_age)))
                begin
                    best = e;
                    best_age = a;
                end
            end
        end
        return best;
    endfunction

    function automatic evict_result_t apply_request(logic [CMD_W-1:0] c,
                                                    logic [IDX_W-1:0] idx,
                                                    logic [PID_W-1:0] pid);
        evict_result_t r;
        int slot;
        int victim;
        int cand;
        int requeues;
        r = '0;
        slot = -1;
        victim = -1;
        requeues = 0;
        case (c)
            CMD_PLACE:
            begin
                pm_active[idx] = 1'b1;
                pm_present[idx] = 1'b1;
                pm_refd[idx] = 1'b0;
                pm_pid[idx] = pid;
                pm_seq[idx] = pm_seq_ctr;
                pm_seq_ctr = pm_seq_ctr + 1'b1;
            end
            CMD_REFERENCE:
            begin
                if (pm_active[idx])
                    pm_refd[idx] = 1'b1;
            end
            CMD_RELEASE:
            begin
                pm_active[idx] = 1'b0;
                pm_present[idx] = 1'b0;
                pm_refd[idx] = 1'b0;
                pm_seq[idx] = '0;
                pm_pid[idx] = '0;
            end
            default:
            begin
                for (int s = NUM_SLOTS - 1; s >= 0; s--)
                    if (pm_owner[s] == '0)
                        slot = s;
                if (slot < 0)
                    r.st = ST_NO_SLOT;
                else if (pm_policy == POLICY_LIFO)
                begin
                    victim = pick_page(1'b0);
                    if (victim < 0)
                        r.st = ST_NO_VICTIM;
                end
                else
                begin
                    forever
                    begin
                        cand = pick_page(1'b1);
                        if (cand < 0)
                        begin
                            r.st = ST_NO_VICTIM;
                            break;
                        end
                        if (!pm_refd[cand])
                        begin
                            victim = cand;
                            break;
                        end
                        if (requeues >= NUM_ENTRIES)
                        begin
                            r.st = ST_NO_VICTIM;
                            break;
                        end
                        pm_refd[cand] = 1'b0;
                        pm_seq[cand] = pm_seq_ctr;
                        pm_seq_ctr = pm_seq_ctr + 1'b1;
                        requeues++;
                    end
                end
                if (r.st == ST_DONE && victim >= 0)
                begin
                    pm_present[victim] = 1'b0;
                    pm_seq[victim] = '0;
                    pm_owner[slot] = pm_pid[victim];
                    r.ventry = victim[IDX_W-1:0];
                    r.vpid = pm_pid[victim];
                    r.slot = slot[SLOT_W-1:0];
                end
            end
        endcase
        return r;
    endfunction

    task automatic send_request(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                                logic [PID_W-1:0] pid, bit typed, evict_result_t res);
        evict_result_t predicted;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        entry_index <= idx;
        page_id <= pid;
        do @(posedge clk); while (in_stall);
        predicted = apply_request(c, idx, pid);
        pending_results.push_back(typed ? res : predicted);
    endtask

    task automatic write_policy(logic mode);
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        @(posedge clk);
        cfg_valid <= 1'b1;
        policy_mode <= mode;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pm_policy = mode;
    endtask

    function automatic void add_row(logic [CMD_W-1:0] c, logic [IDX_W-1:0] idx,
                                    logic [PID_W-1:0] pid, bit typed,
                                    logic [STATUS_W-1:0] st, logic [IDX_W-1:0] ve,
                                    logic [PID_W-1:0] vp, logic [SLOT_W-1:0] sl);
        request_row_t row;
        row.c = c;
        row.idx = idx;
        row.pid = pid;
        row.typed = typed;
        row.res = '{st, ve, vp, sl};
        directed_rows.push_back(row);
    endfunction

    always @(posedge clk)
    begin
        evict_result_t exp_res;
        if (out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("Unexpected result: status=%0d entry=%0d page=%h slot=%0d",
                             status, victim_entry, victim_page_id, swap_slot);
            end
            else
            begin
                exp_res = pending_results.pop_front();
                if (status !== exp_res.st || victim_entry !== exp_res.ventry ||
                    victim_page_id !== exp_res.vpid || swap_slot !== exp_res.slot)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected %0d/%0d/%h/%0d got %0d/%0d/%h/%0d",
                                 exp_res.st, exp_res.ventry, exp_res.vpid, exp_res.slot,
                                 status, victim_entry, victim_page_id, swap_slot);
                end
            end
        end
        if (stall_left > 0)
        begin
            stall_left--;
            out_stall <= 1'b1;
        end
        else if (idle_on && $urandom_range(0, 5) == 0)
        begin
            stall_left = $urandom_range(0, 7);
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    initial
    begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        int r;
        logic [CMD_W-1:0] c;
        logic [PID_W-1:0] pid;
        rst_n = 1'b0;
        in_valid = 1'b0;
        cmd = CMD_PLACE;
        entry_index = '0;
        page_id = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        policy_mode = POLICY_FIFO;
        errors = 0;
        idle_on = 1'b1;
        stall_left = 0;
        pm_policy = POLICY_FIFO;
        pm_seq_ctr = '0;
        for (int e = 0; e < NUM_ENTRIES; e++)
        begin
            pm_active[e] = 1'b0;
            pm_present[e] = 1'b0;
            pm_refd[e] = 1'b0;
            pm_seq[e] = '0;
            pm_pid[e] = '0;
        end
        for (int s = 0; s < NUM_SLOTS; s++)
            pm_owner[s] = '0;

        add_row(CMD_EVICT, 0, 0, 1, ST_NO_VICTIM, 0, 0, 0);
        add_row(CMD_PLACE, 0, 16'hFFFF, 1, ST_DONE, 0, 0, 0);
        add_row(CMD_PLACE, 31, 16'h0001, 1, ST_DONE, 0, 0, 0);
        add_row(CMD_REFERENCE, 31, 0, 1, ST_DONE, 0, 0, 0);
        add_row(CMD_REFERENCE, 5, 0, 1, ST_DONE, 0, 0, 0);
        add_row(CMD_EVICT, 0, 0, 1, ST_DONE, 0, 16'hFFFF, 0);
        add_row(CMD_EVICT, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_PLACE, 3, 16'h0000, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_PLACE, 3, 16'h1234, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_RELEASE, 3, 0, 1, ST_DONE, 0, 0, 0);
        add_row(CMD_EVICT, 0, 0, 1, ST_NO_VICTIM, 0, 0, 0);
        add_row(CMD_PLACE, 7, 16'h0000, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_PLACE, 8, 16'h0000, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_REFERENCE, 7, 0, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_REFERENCE, 8, 0, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_EVICT, 0, 0, 0, ST_DONE, 0, 0, 0);
        add_row(CMD_RELEASE, 31, 0, 0, ST_DONE, 0, 0, 0);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_policy(POLICY_FIFO);
        foreach (directed_rows[i])
            send_request(directed_rows[i].c, directed_rows[i].idx, directed_rows[i].pid,
                         directed_rows[i].typed, directed_rows[i].res);

        write_policy(POLICY_LIFO);
        send_request(CMD_PLACE, 10, 16'h00AA, 0, '0);
        send_request(CMD_PLACE, 11, 16'h0000, 0, '0);
        send_request(CMD_EVICT, 0, 0, 0, '0);
        send_request(CMD_EVICT, 0, 0, 0, '0);

        for (int phase = 0; phase < 4; phase++)
        begin
            write_policy(phase[0] ? POLICY_FIFO : POLICY_LIFO);
            if (phase == 3)
                idle_on = 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    c = CMD_PLACE;
                else if (r < 60)
                    c = CMD_REFERENCE;
                else if (r < 88)
                    c = CMD_EVICT;
                else
                    c = CMD_RELEASE;
                pid = ($urandom_range(0, 99) < 5) ? 16'($urandom_range(1, 65535)) : 16'h0000;
                send_request(c, 5'($urandom_range(0, 31)), pid, 0, '0);
            end
        end
        in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
